[hdl/assert_macros.svh]
// assertion macros used by the block transfer sender
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hdl/bts_pkg.sv]
// constants, codes and types of the block transfer sender
package bts_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 5;
    localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);

    localparam logic [7:0] C_SOH = 8'h01;
    localparam logic [7:0] C_EOT = 8'h04;
    localparam logic [7:0] C_ACK = 8'h06;
    localparam logic [7:0] C_NAK = 8'h15;
    localparam logic [7:0] C_ESC = 8'd27;

    localparam logic [2:0] FUNC_START   = 3'd0;
    localparam logic [2:0] FUNC_PAYLOAD = 3'd1;
    localparam logic [2:0] FUNC_RX      = 3'd2;
    localparam logic [2:0] FUNC_TICK    = 3'd3;
    localparam logic [2:0] FUNC_SLOT    = 3'd4;

    localparam logic KIND_LINE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_HDR_ACK  = 2'd0;
    localparam logic [1:0] ST_DATA_ACK = 2'd1;
    localparam logic [1:0] ST_DONE     = 2'd2;
    localparam logic [1:0] ST_FAILED   = 2'd3;

    localparam logic [1:0] REG_BLOCK_COUNT = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] REG_REPLY_WIN   = 2'd2;
    localparam logic [1:0] REG_SETTLE      = 2'd3;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

[hdl/block_transfer_sender.sv]
// block transfer sender: escape pair, settle time, framed blocks with retries, eot
// Usage:
//   s_* channel takes one item per cycle while s_tready is high; s_tuser selects
//   the function (start, payload byte, received byte, tick, transmit slot), s_tdata
//   carries the payload byte and received byte, s_tlast marks the last payload
//   byte of a block. m_* channel returns at most one item per input item: a line byte
//   (m_tuser = 0) or a status event (m_tuser = 1) with block number and miss count.
//   cfg_* writes the block count, retry limit, reply window and settle time; it is
//   always ready; the user writes it only while the block is idle, which it does not enforce.
//   Throughput: one input item per cycle while the output is not stalled. A result
//   reaches m_tvalid through the stage register, alongside the registered read of
//   the frame store, followed by the output register.
//   When m_tready is low the output register and the stage in front of it hold,
//   and s_tready falls once both are full; no item is lost.
//   Reset clears the sequencer to idle and loads the register defaults
//   (1, 10, 230, 150); the frame store needs no clearing.
module block_transfer_sender
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // payload_byte, rx_byte
    input  logic [2:0]  s_tuser,   // func
    input  logic        s_tlast,   // payload_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // line_byte, status_code, block_index, miss_count, zero pad
    output logic [0:0]  m_tuser,   // out_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        PH_IDLE, PH_ESC1, PH_ESC2, PH_SETTLE, PH_LOAD, PH_SEND,
        PH_WAIT, PH_ABORT1, PH_ABORT2, PH_EOT, PH_EOTWAIT
    } phase_t;

    localparam logic [7:0] PB_LEN   = 8'(bts_pkg::PAYLOAD_BYTES);
    localparam logic [7:0] FR_LEN   = 8'(bts_pkg::FRAME_BYTES);
    localparam logic [7:0] SUM_LO_P = 8'(bts_pkg::PAYLOAD_BYTES + 3);

    phase_t      phase_reg, phase_next;
    logic [15:0] block_cnt_reg, block_cnt_next;
    logic [7:0]  load_pos_reg, load_pos_next;
    logic [7:0]  send_pos_reg, send_pos_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  tries_reg, tries_next;
    logic [15:0] timer_reg, timer_next;
    logic [7:0]  misses_reg, misses_next;

    logic [15:0] blocks_cfg_reg;
    logic [7:0]  retry_cfg_reg;
    logic [15:0] reply_cfg_reg;
    logic [15:0] settle_cfg_reg;

    logic        p1_valid_reg;
    logic        p1_kind_reg;
    logic [7:0]  p1_byte_reg;
    logic        p1_use_mem_reg;
    logic [1:0]  p1_code_reg;
    logic [15:0] p1_index_reg;
    logic [7:0]  p1_miss_reg;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic [0:0]  m_tuser_reg;

    logic        accept;
    logic        out_free;
    logic        p1_move;
    logic [2:0]  func;
    logic [7:0]  pb;
    logic [7:0]  rx;
    logic [7:0]  lp_inc;
    logic [7:0]  sp_inc;
    logic [7:0]  pay_idx;
    logic [15:0] timer_dec;
    logic        ack_ev;
    logic        miss_ev;
    logic        load_ev;
    logic        res_valid;
    logic        res_kind;
    logic [7:0]  res_byte;
    logic        res_use_mem;
    logic [1:0]  res_code;
    logic [7:0]  rd_data;
    logic [7:0]  out_byte;

    bts_pkg::mem_req_t mem_req;

    bts_frame_buf u_frame_buf
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign out_free  = !m_tvalid_reg || m_tready;
    assign p1_move   = p1_valid_reg && out_free;
    assign s_tready  = !p1_valid_reg || out_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign func      = s_tuser;
    assign pb        = s_tdata[7:0];
    assign rx        = s_tdata[15:8];
    assign lp_inc    = load_pos_reg + 8'd1;
    assign sp_inc    = send_pos_reg + 8'd1;
    assign pay_idx   = send_pos_reg - 8'd3;
    assign timer_dec = (timer_reg != 16'd0) ? timer_reg - 16'd1 : 16'd0;

    assign out_byte  = p1_use_mem_reg ? rd_data : p1_byte_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        block_cnt_next = block_cnt_reg;
        load_pos_next  = load_pos_reg;
        send_pos_next  = send_pos_reg;
        sum_next       = sum_reg;
        tries_next     = tries_reg;
        timer_next     = timer_reg;
        misses_next    = misses_reg;
        ack_ev         = 1'b0;
        miss_ev        = 1'b0;
        load_ev        = 1'b0;
        res_valid      = 1'b0;
        res_kind       = bts_pkg::KIND_LINE;
        res_byte       = 8'd0;
        res_use_mem    = 1'b0;
        res_code       = bts_pkg::ST_HDR_ACK;
        mem_req        = '0;

        if (accept)
        begin
            case (func)
                bts_pkg::FUNC_START:
                begin
                    block_cnt_next = 16'd0;
                    load_pos_next  = 8'd0;
                    send_pos_next  = 8'd0;
                    sum_next       = 16'd0;
                    tries_next     = retry_cfg_reg;
                    timer_next     = 16'd0;
                    phase_next     = PH_ESC1;
                end
                bts_pkg::FUNC_PAYLOAD:
                begin
                    if (phase_reg == PH_LOAD)
                    begin
                        if (load_pos_reg < PB_LEN)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = load_pos_reg[bts_pkg::ADDR_W-1:0];
                            mem_req.wr_data = pb;
                            sum_next        = sum_reg + {8'd0, pb};
                            load_pos_next   = lp_inc;
                        end
                        if (s_tlast || load_pos_next >= PB_LEN)
                        begin
                            send_pos_next = 8'd0;
                            phase_next    = PH_SEND;
                        end
                    end
                end
                bts_pkg::FUNC_RX:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        ack_ev  = (rx == bts_pkg::C_ACK);
                        miss_ev = (rx == bts_pkg::C_NAK);
                    end
                    else if (phase_reg == PH_EOTWAIT &&
                             (rx == bts_pkg::C_ACK || rx == bts_pkg::C_NAK))
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_kind   = bts_pkg::KIND_STATUS;
                        res_code   = bts_pkg::ST_DONE;
                    end
                end
                bts_pkg::FUNC_TICK:
                begin
                    if (phase_reg == PH_SETTLE || phase_reg == PH_WAIT ||
                        phase_reg == PH_EOTWAIT)
                    begin
                        timer_next = timer_dec;
                        if (timer_dec == 16'd0)
                        begin
                            if (phase_reg == PH_SETTLE)
                            begin
                                load_ev = 1'b1;
                            end
                            else if (phase_reg == PH_WAIT)
                            begin
                                miss_ev = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res_kind   = bts_pkg::KIND_STATUS;
                                res_code   = bts_pkg::ST_DONE;
                            end
                        end
                    end
                end
                bts_pkg::FUNC_SLOT:
                begin
                    case (phase_reg)
                        PH_ESC1:
                        begin
                            phase_next = PH_ESC2;
                            res_valid  = 1'b1;
                            res_byte   = bts_pkg::C_ESC;
                        end
                        PH_ESC2:
                        begin
                            if (settle_cfg_reg == 16'd0)
                            begin
                                load_ev = 1'b1;
                            end
                            else
                            begin
                                timer_next = settle_cfg_reg;
                                phase_next = PH_SETTLE;
                            end
                            res_valid = 1'b1;
                            res_byte  = bts_pkg::C_ESC;
                        end
                        PH_SEND:
                        begin
                            res_valid     = 1'b1;
                            send_pos_next = sp_inc;
                            if (sp_inc >= FR_LEN)
                            begin
                                timer_next = reply_cfg_reg;
                                phase_next = PH_WAIT;
                            end
                            if (send_pos_reg == 8'd0)
                            begin
                                res_byte = bts_pkg::C_SOH;
                            end
                            else if (send_pos_reg == 8'd1)
                            begin
                                res_byte = block_cnt_reg[7:0];
                            end
                            else if (send_pos_reg == 8'd2)
                            begin
                                res_byte = ~block_cnt_reg[7:0];
                            end
                            else if (send_pos_reg < SUM_LO_P)
                            begin
                                // bytes beyond the fill mark go out as zero
                                res_use_mem     = (pay_idx < load_pos_reg);
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = pay_idx[bts_pkg::ADDR_W-1:0];
                            end
                            else if (send_pos_reg == SUM_LO_P)
                            begin
                                res_byte = sum_reg[7:0];
                            end
                            else
                            begin
                                res_byte = sum_reg[15:8];
                            end
                        end
                        PH_ABORT1:
                        begin
                            phase_next = PH_ABORT2;
                            res_valid  = 1'b1;
                            res_byte   = bts_pkg::C_ESC;
                        end
                        PH_ABORT2:
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_byte   = bts_pkg::C_ESC;
                        end
                        PH_EOT:
                        begin
                            timer_next = reply_cfg_reg;
                            phase_next = PH_EOTWAIT;
                            res_valid  = 1'b1;
                            res_byte   = bts_pkg::C_EOT;
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase

            // nak or reply timeout
            if (miss_ev)
            begin
                misses_next = misses_reg + 8'd1;
                if (tries_reg <= 8'd1)
                begin
                    tries_next = 8'd0;
                    phase_next = (block_cnt_reg == 16'd0) ? PH_IDLE : PH_ABORT1;
                    res_valid  = 1'b1;
                    res_kind   = bts_pkg::KIND_STATUS;
                    res_code   = bts_pkg::ST_FAILED;
                end
                else
                begin
                    tries_next    = tries_reg - 8'd1;
                    send_pos_next = 8'd0;
                    phase_next    = PH_SEND;
                end
            end

            if (ack_ev)
            begin
                res_valid = 1'b1;
                res_kind  = bts_pkg::KIND_STATUS;
                res_code  = (block_cnt_reg == 16'd0) ? bts_pkg::ST_HDR_ACK
                                                      : bts_pkg::ST_DATA_ACK;
                if (block_cnt_reg >= blocks_cfg_reg)
                begin
                    phase_next = PH_EOT;
                end
                else
                begin
                    block_cnt_next = block_cnt_reg + 16'd1;
                    load_ev        = 1'b1;
                end
            end

            if (load_ev)
            begin
                phase_next    = PH_LOAD;
                load_pos_next = 8'd0;
                send_pos_next = 8'd0;
                sum_next      = 16'd0;
                tries_next    = retry_cfg_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            block_cnt_reg  <= 16'd0;
            load_pos_reg   <= 8'd0;
            send_pos_reg   <= 8'd0;
            sum_reg        <= 16'd0;
            tries_reg      <= 8'd0;
            timer_reg      <= 16'd0;
            misses_reg     <= 8'd0;
            blocks_cfg_reg <= 16'd1;
            retry_cfg_reg  <= 8'd10;
            reply_cfg_reg  <= 16'd230;
            settle_cfg_reg <= 16'd150;
            p1_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            block_cnt_reg <= block_cnt_next;
            load_pos_reg  <= load_pos_next;
            send_pos_reg  <= send_pos_next;
            sum_reg       <= sum_next;
            tries_reg     <= tries_next;
            timer_reg     <= timer_next;
            misses_reg    <= misses_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bts_pkg::REG_BLOCK_COUNT: blocks_cfg_reg <= cfg_data;
                    bts_pkg::REG_RETRY_LIMIT: retry_cfg_reg  <= cfg_data[7:0];
                    bts_pkg::REG_REPLY_WIN:   reply_cfg_reg  <= cfg_data;
                    bts_pkg::REG_SETTLE:      settle_cfg_reg <= cfg_data;
                    default:                  settle_cfg_reg <= settle_cfg_reg;
                endcase
            end

            if (accept)
            begin
                p1_valid_reg <= res_valid;
            end
            else if (p1_move)
            begin
                p1_valid_reg <= 1'b0;
            end

            if (p1_move)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload of the two result stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_kind_reg    <= res_kind;
            p1_byte_reg    <= res_byte;
            p1_use_mem_reg <= res_use_mem;
            p1_code_reg    <= res_code;
            p1_index_reg   <= block_cnt_reg;
            p1_miss_reg    <= misses_next;
        end
        if (p1_move)
        begin
            m_tdata_reg <= {6'd0, p1_miss_reg, p1_index_reg, p1_code_reg, out_byte};
            m_tuser_reg <= p1_kind_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst_n,
        p1_valid_reg && m_tvalid_reg && !m_tready, !s_tready)
    `ASSERT_IMPLIES(a_fill_mark_bound, clk, rst_n, 1'b1, load_pos_reg <= PB_LEN)
    `ASSERT_IMPLIES(a_send_pos_bound, clk, rst_n, phase_reg == PH_SEND,
        send_pos_reg < FR_LEN)
    `ASSERT_NEXT(a_ack_gives_status, clk, rst_n,
        accept && phase_reg == PH_WAIT && func == bts_pkg::FUNC_RX &&
        rx == bts_pkg::C_ACK, p1_valid_reg && p1_kind_reg == bts_pkg::KIND_STATUS)

endmodule

[hdl/bts_frame_buf.sv]
// payload store of one block, one write and one registered read per cycle
module bts_frame_buf
(
    input  logic              clk,
    input  bts_pkg::mem_req_t req,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [bts_pkg::PAYLOAD_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sim/block_transfer_sender_tb.sv]
// self-checking testbench for the block transfer sender: directed transfers, then random sessions
`timescale 1ns / 100ps

module block_transfer_sender_tb;

    import bts_pkg::*;

    localparam int PIPE_SETTLE = 8;
    localparam int LONG_HOLD   = 300;
    localparam logic [1:0] NO_STATUS = 2'd0;

    typedef enum logic [3:0] {
        P_IDLE, P_ESC1, P_ESC2, P_SETTLE, P_LOAD, P_SEND,
        P_WAIT, P_ABORT1, P_ABORT2, P_EOT, P_EOTWAIT
    } sender_phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  line;
        logic [1:0]  code;
        logic [15:0] blk;
        logic [7:0]  miss;
    } tx_event_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // payload_byte, rx_byte
    logic [2:0]  s_tuser;   // func
    logic        s_tlast;   // payload_end
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // line_byte, status_code, block_index, miss_count, zero pad
    logic [0:0]  m_tuser;   // out_kind
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // copy of the sender state
    sender_phase_t ph;
    logic [7:0]    frame_copy [PAYLOAD_BYTES];
    logic [15:0]   blk_count;
    logic [7:0]    load_pos;
    logic [7:0]    send_pos;
    logic [15:0]   csum;
    logic [7:0]    tries;
    logic [15:0]   timer;
    logic [7:0]    miss_total;
    logic [15:0]   cfg_blocks;
    logic [7:0]    cfg_retry;
    logic [15:0]   cfg_window;
    logic [15:0]   cfg_settle;

    tx_event_t line_events_due [$];
    tx_event_t head_event;
    int        fail_count = 0;

    int ack_pct = 100;
    int nak_pct = 0;
    int end_pct = 100;
    bit gaps_on = 1'b0;
    bit ready_random = 1'b0;
    bit long_hold_req = 1'b0;

    block_transfer_sender u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void note_line_event(logic kind, logic [7:0] byte_val, logic [1:0] code);
        line_events_due.push_back('{kind: kind, line: byte_val, code: code,
                                    blk: blk_count, miss: miss_total});
    endfunction

    function automatic void start_block_load();
        ph       = P_LOAD;
        load_pos = 8'd0;
        send_pos = 8'd0;
        csum     = 16'd0;
        tries    = cfg_retry;
    endfunction

    function automatic void count_miss();
        miss_total = miss_total + 8'd1;
        if (tries <= 8'd1)
        begin
            tries = 8'd0;
            ph = (blk_count == 16'd0) ? P_IDLE : P_ABORT1;
            note_line_event(KIND_STATUS, 8'h00, ST_FAILED);
        end
        else
        begin
            tries    = tries - 8'd1;
            send_pos = 8'd0;
            ph       = P_SEND;
        end
    endfunction

    function automatic void predict_sender_step(logic [2:0] func, logic [7:0] pb, logic pe,
                                                logic [7:0] rx);
        logic [7:0] tx_val;
        logic [7:0] idx;
        case (func)
            FUNC_START:
            begin
                blk_count = 16'd0;
                load_pos  = 8'd0;
                send_pos  = 8'd0;
                csum      = 16'd0;
                tries     = cfg_retry;
                timer     = 16'd0;
                ph        = P_ESC1;
            end
            FUNC_PAYLOAD:
            begin
                if (ph == P_LOAD)
                begin
                    if (load_pos < PAYLOAD_BYTES)
                    begin
                        frame_copy[load_pos[ADDR_W-1:0]] = pb;
                        csum     = csum + 16'(pb);
                        load_pos = load_pos + 8'd1;
                    end
                    if (pe || load_pos >= PAYLOAD_BYTES)
                    begin
                        send_pos = 8'd0;
                        ph       = P_SEND;
                    end
                end
            end
            FUNC_RX:
            begin
                if (ph == P_WAIT)
                begin
                    if (rx == C_ACK)
                    begin
                        note_line_event(KIND_STATUS, 8'h00,
                                        (blk_count == 16'd0) ? ST_HDR_ACK : ST_DATA_ACK);
                        if (blk_count >= cfg_blocks)
                            ph = P_EOT;
                        else
                        begin
                            blk_count = blk_count + 16'd1;
                            start_block_load();
                        end
                    end
                    else if (rx == C_NAK)
                        count_miss();
                end
                else if (ph == P_EOTWAIT && (rx == C_ACK || rx == C_NAK))
                begin
                    ph = P_IDLE;
                    note_line_event(KIND_STATUS, 8'h00, ST_DONE);
                end
            end
            FUNC_TICK:
            begin
                if (ph == P_SETTLE || ph == P_WAIT || ph == P_EOTWAIT)
                begin
                    if (timer > 16'd0)
                        timer = timer - 16'd1;
                    if (timer == 16'd0)
                    begin
                        if (ph == P_SETTLE)
                            start_block_load();
                        else if (ph == P_WAIT)
                            count_miss();
                        else
                        begin
                            ph = P_IDLE;
                            note_line_event(KIND_STATUS, 8'h00, ST_DONE);
                        end
                    end
                end
            end
            FUNC_SLOT:
            begin
                case (ph)
                    P_ESC1:
                    begin
                        ph = P_ESC2;
                        note_line_event(KIND_LINE, C_ESC, NO_STATUS);
                    end
                    P_ESC2:
                    begin
                        if (cfg_settle == 16'd0)
                            start_block_load();
                        else
                        begin
                            timer = cfg_settle;
                            ph    = P_SETTLE;
                        end
                        note_line_event(KIND_LINE, C_ESC, NO_STATUS);
                    end
                    P_SEND:
                    begin
                        if (send_pos == 8'd0)
                            tx_val = C_SOH;
                        else if (send_pos == 8'd1)
                            tx_val = blk_count[7:0];
                        else if (send_pos == 8'd2)
                            tx_val = ~blk_count[7:0];
                        else if (send_pos < 3 + PAYLOAD_BYTES)
                        begin
                            idx    = send_pos - 8'd3;
                            tx_val = (idx < load_pos) ? frame_copy[idx[ADDR_W-1:0]] : 8'h00;
                        end
                        else if (send_pos == 3 + PAYLOAD_BYTES)
                            tx_val = csum[7:0];
                        else
                            tx_val = csum[15:8];
                        send_pos = send_pos + 8'd1;
                        if (send_pos >= FRAME_BYTES)
                        begin
                            timer = cfg_window;
                            ph    = P_WAIT;
                        end
                        note_line_event(KIND_LINE, tx_val, NO_STATUS);
                    end
                    P_ABORT1:
                    begin
                        ph = P_ABORT2;
                        note_line_event(KIND_LINE, C_ESC, NO_STATUS);
                    end
                    P_ABORT2:
                    begin
                        ph = P_IDLE;
                        note_line_event(KIND_LINE, C_ESC, NO_STATUS);
                    end
                    P_EOT:
                    begin
                        timer = cfg_window;
                        ph    = P_EOTWAIT;
                        note_line_event(KIND_LINE, C_EOT, NO_STATUS);
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    endfunction

    // result side: random stalls and the long hold-off
    initial
    begin
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (ready_random && $urandom_range(0, 99) < 25)
            begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (line_events_due.size() == 0)
            begin
                $error("unexpected item: out_kind %0d m_tdata %h", m_tuser[0], m_tdata);
                fail_count++;
            end
            else
            begin
                head_event = line_events_due.pop_front();
                if (m_tuser[0] !== head_event.kind)
                begin
                    $error("out_kind expected %0d got %0d", head_event.kind, m_tuser[0]);
                    fail_count++;
                end
                if (m_tdata[7:0] !== head_event.line)
                begin
                    $error("line_byte expected %h got %h", head_event.line, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[9:8] !== head_event.code)
                begin
                    $error("status_code expected %0d got %0d", head_event.code, m_tdata[9:8]);
                    fail_count++;
                end
                if (m_tdata[25:10] !== head_event.blk)
                begin
                    $error("block_index expected %0d got %0d", head_event.blk, m_tdata[25:10]);
                    fail_count++;
                end
                if (m_tdata[33:26] !== head_event.miss)
                begin
                    $error("miss_count expected %0d got %0d", head_event.miss, m_tdata[33:26]);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_item(input logic [2:0] func, input logic [7:0] pb, input logic pe,
                             input logic [7:0] rx);
        int idle_len;
        if (gaps_on && $urandom_range(0, 99) < 30)
        begin
            idle_len = gap_len();
            s_tvalid <= 1'b0;
            repeat (idle_len) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {rx, pb};
        s_tlast  <= pe;
        do
            @(posedge clk);
        while (!s_tready);
        predict_sender_step(func, pb, pe, rx);
    endtask

    task automatic drain_line_events();
        s_tvalid <= 1'b0;
        while (line_events_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic set_registers(input logic [15:0] blocks, input logic [15:0] retry,
                                 input logic [15:0] window, input logic [15:0] settle);
        logic [1:0]  regs [4];
        logic [15:0] vals [4];
        regs[0] = REG_BLOCK_COUNT;
        regs[1] = REG_RETRY_LIMIT;
        regs[2] = REG_REPLY_WIN;
        regs[3] = REG_SETTLE;
        vals[0] = blocks;
        vals[1] = retry;
        vals[2] = window;
        vals[3] = settle;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (regs[i])
                REG_BLOCK_COUNT: cfg_blocks = vals[i];
                REG_RETRY_LIMIT: cfg_retry  = vals[i][7:0];
                REG_REPLY_WIN:   cfg_window = vals[i];
                default:         cfg_settle = vals[i];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_policy(input int ack, input int nak, input int endp);
        ack_pct = ack;
        nak_pct = nak;
        end_pct = endp;
    endtask

    // the item that moves the transfer on from the current phase
    task automatic send_wellformed();
        int pick;
        pick = $urandom_range(0, 99);
        case (ph)
            P_IDLE:
                send_item(FUNC_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
            P_SETTLE:
                send_item(FUNC_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
            P_LOAD:
                send_item(FUNC_PAYLOAD, 8'($urandom_range(0, 255)), pick < end_pct,
                          8'($urandom_range(0, 255)));
            P_WAIT, P_EOTWAIT:
            begin
                if (pick < ack_pct)
                    send_item(FUNC_RX, 8'($urandom_range(0, 255)), 1'b0, C_ACK);
                else if (pick < ack_pct + nak_pct)
                    send_item(FUNC_RX, 8'($urandom_range(0, 255)), 1'b1, C_NAK);
                else
                    send_item(FUNC_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
            end
            default:
                send_item(FUNC_SLOT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic run_until(input sender_phase_t target);
        do
            send_wellformed();
        while (ph != target);
    endtask

    task automatic test_ignored_when_idle();
        send_item(FUNC_PAYLOAD, 8'hFF, 1'b1, 8'h00);
        send_item(FUNC_PAYLOAD, 8'h00, 1'b0, 8'hFF);
        send_item(FUNC_RX, 8'h00, 1'b0, C_ACK);
        send_item(FUNC_RX, 8'hFF, 1'b1, C_NAK);
        send_item(FUNC_TICK, 8'h00, 1'b0, 8'h00);
        send_item(FUNC_SLOT, 8'hFF, 1'b1, 8'hFF);
        for (int f = FUNC_SLOT + 1; f < 8; f++)
            send_item(3'(f), 8'hA5, 1'b1, 8'h5A);
        drain_line_events();
    endtask

    // reset register values, full 128-byte payloads
    task automatic test_default_transfer();
        set_policy(100, 0, 0);
        run_until(P_IDLE);
        drain_line_events();
    endtask

    task automatic test_zero_settings();
        set_registers(16'd0, 16'd0, 16'd0, 16'd0);
        set_policy(0, 0, 100);
        run_until(P_IDLE);
        set_policy(100, 0, 100);
        run_until(P_EOTWAIT);
        send_item(FUNC_TICK, 8'h00, 1'b0, 8'h00);
        drain_line_events();
    endtask

    task automatic test_header_failure();
        set_registers(16'd1, 16'd1, 16'd5, 16'd2);
        set_policy(0, 100, 50);
        run_until(P_IDLE);
        drain_line_events();
        set_registers(16'd1, 16'd3, 16'd2, 16'd0);
        set_policy(0, 60, 50);
        run_until(P_IDLE);
        drain_line_events();
    endtask

    task automatic test_data_failure();
        set_registers(16'd2, 16'd2, 16'd1, 16'd1);
        set_policy(100, 0, 30);
        run_until(P_WAIT);
        send_item(FUNC_RX, 8'h00, 1'b0, C_ACK);
        run_until(P_WAIT);
        send_item(FUNC_RX, 8'h00, 1'b0, C_NAK);
        run_until(P_WAIT);
        send_item(FUNC_TICK, 8'h00, 1'b0, 8'h00);
        run_until(P_IDLE);
        drain_line_events();
    endtask

    task automatic test_eot_replies();
        set_registers(16'd0, 16'd3, 16'd2, 16'd2);
        set_policy(100, 0, 100);
        run_until(P_SETTLE);
        // replies during the settle time are dropped
        send_item(FUNC_RX, 8'h00, 1'b0, C_ACK);
        run_until(P_EOTWAIT);
        send_item(FUNC_RX, 8'h00, 1'b0, 8'h00);
        send_item(FUNC_RX, 8'h00, 1'b0, C_ACK);
        run_until(P_EOTWAIT);
        send_item(FUNC_RX, 8'h00, 1'b0, C_NAK);
        run_until(P_EOTWAIT);
        send_item(FUNC_TICK, 8'h00, 1'b0, 8'h00);
        send_item(FUNC_TICK, 8'h00, 1'b0, 8'h00);
        drain_line_events();
    endtask

    task automatic test_restart_while_busy();
        set_registers(16'd2, 16'd4, 16'd3, 16'd1);
        set_policy(50, 50, 20);
        gaps_on = 1'b1;
        run_until(P_ESC2);
        send_item(FUNC_START, 8'h00, 1'b0, 8'h00);
        run_until(P_LOAD);
        repeat (3) send_item(FUNC_PAYLOAD, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
        send_item(FUNC_START, 8'h00, 1'b0, 8'h00);
        run_until(P_SEND);
        repeat (5) send_item(FUNC_SLOT, 8'h00, 1'b0, 8'h00);
        send_item(FUNC_START, 8'h00, 1'b0, 8'h00);
        run_until(P_WAIT);
        send_item(FUNC_RX, 8'h00, 1'b0, C_NAK);
        send_item(FUNC_START, 8'h00, 1'b0, 8'h00);
        run_until(P_WAIT);
        send_item(FUNC_START, 8'h00, 1'b0, 8'h00);
        set_policy(100, 0, 50);
        run_until(P_IDLE);
        gaps_on = 1'b0;
        drain_line_events();
    endtask

    task automatic test_backpressure();
        set_registers(16'd1, 16'd2, 16'd4, 16'd0);
        set_policy(100, 0, 0);
        run_until(P_SEND);
        long_hold_req = 1'b1;
        repeat (120) send_item(FUNC_SLOT, 8'h00, 1'b0, 8'h00);
        drain_line_events();
        run_until(P_IDLE);
        drain_line_events();
    endtask

    task automatic test_register_extremes();
        set_registers(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
        set_policy(100, 0, 100);
        run_until(P_WAIT);
        repeat (10) send_item(FUNC_TICK, 8'h00, 1'b0, 8'h00);
        send_item(FUNC_RX, 8'h00, 1'b0, C_ACK);
        run_until(P_WAIT);
        send_item(FUNC_RX, 8'h00, 1'b0, C_NAK);
        run_until(P_IDLE);
        drain_line_events();
        set_registers(16'd1, 16'd255, 16'd1, 16'd0);
        set_policy(70, 30, 50);
        run_until(P_IDLE);
        drain_line_events();
    endtask

    // enough data blocks for the block number field to wrap
    task automatic test_block_number_wrap();
        set_registers(16'd257, 16'd1, 16'd1, 16'd0);
        set_policy(100, 0, 100);
        run_until(P_IDLE);
        drain_line_events();
    endtask

    task automatic random_traffic(input int count);
        int moved;
        int pick;
        moved = 0;
        while (moved < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                send_item(FUNC_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
                moved++;
            end
            else if (pick < 14)
                send_item(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)),
                          ($urandom_range(0, 99) < 30) ?
                              (($urandom_range(0, 1) == 1) ? C_ACK : C_NAK) :
                              8'($urandom_range(0, 255)));
            else
            begin
                send_wellformed();
                moved++;
            end
        end
    endtask

    task automatic test_random_sessions();
        for (int s = 0; s < 6; s++)
        begin
            gaps_on      = (s % 2) == 1;
            ready_random = (s % 3) != 0;
            set_registers(16'($urandom_range(0, 3)), 16'($urandom_range(0, 5)),
                          16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)));
            set_policy(55, 25, 20);
            random_traffic(285);
            if (ph != P_IDLE)
            begin
                set_policy(100, 0, 100);
                run_until(P_IDLE);
            end
            drain_line_events();
        end
        gaps_on      = 1'b0;
        ready_random = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 16'h0000;
        s_tuser   <= FUNC_START;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_BLOCK_COUNT;
        cfg_data  <= 16'h0000;
        ph         = P_IDLE;
        blk_count  = 16'd0;
        load_pos   = 8'd0;
        send_pos   = 8'd0;
        csum       = 16'd0;
        tries      = 8'd0;
        timer      = 16'd0;
        miss_total = 8'd0;
        cfg_blocks = 16'd1;
        cfg_retry  = 8'd10;
        cfg_window = 16'd230;
        cfg_settle = 16'd150;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_ignored_when_idle();
        test_default_transfer();
        test_zero_settings();
        test_header_failure();
        test_data_failure();
        test_eot_replies();
        test_restart_while_busy();
        test_backpressure();
        test_register_extremes();
        test_block_number_wrap();
        test_random_sessions();
        drain_line_events();

        if (fail_count == 0 && line_events_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[block_transfer_sender.f]
+incdir+hdl
hdl/bts_pkg.sv
hdl/bts_frame_buf.sv
hdl/block_transfer_sender.sv
sim/block_transfer_sender_tb.sv
